### hdl/quantized_int16_add_assert.svh
// Assertion macros shared by the files that check this block.
// Each macro samples on clk_i and is quiet while rst_ni is low.
`ifndef QUANTIZED_INT16_ADD_ASSERT_SVH
`define QUANTIZED_INT16_ADD_ASSERT_SVH

// Same-cycle implication.
`define QIA_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define QIA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/qia_pkg.sv
package qia_pkg;

  // Field widths
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned MULT_W  = 31;
  localparam int unsigned SHIFT_W = 5;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;

  // Operand pre-scale (left shift applied to each input)
  localparam int unsigned PRE_SHIFT = 12;

  // Datapath widths inside the rescale unit
  localparam int unsigned RS_W   = 32;
  localparam int unsigned PROD_W = 2 * RS_W;

  // Rounding bias of the doubling high multiply: 2^30
  localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(64'h0000_0000_4000_0000);

  // Pipeline depth: 3 operand rescale, 1 sum, 3 output rescale, 1 clamp
  localparam int unsigned NSTG = 8;

  // Register reset values
  localparam logic [MULT_W-1:0]        MULT_RST      = MULT_W'(31'h4000_0000);
  localparam logic signed [VAL_W-1:0]  CLAMP_LO_RST  = 16'sh8000;
  localparam logic signed [VAL_W-1:0]  CLAMP_HI_RST  = 16'sh7fff;

  // Register map, word index
  typedef enum logic [2:0] {
    REG_A_MULT    = 3'd0,
    REG_A_SHIFT   = 3'd1,
    REG_B_MULT    = 3'd2,
    REG_B_SHIFT   = 3'd3,
    REG_OUT_MULT  = 3'd4,
    REG_OUT_SHIFT = 3'd5,
    REG_CLAMP_LO  = 3'd6,
    REG_CLAMP_HI  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [MULT_W-1:0]       a_mult;
    logic [SHIFT_W-1:0]      a_shift;
    logic [MULT_W-1:0]       b_mult;
    logic [SHIFT_W-1:0]      b_shift;
    logic [MULT_W-1:0]       out_mult;
    logic [SHIFT_W-1:0]      out_shift;
    logic signed [VAL_W-1:0] clamp_lo;
    logic signed [VAL_W-1:0] clamp_hi;
  } cfg_t;

  // Load enables of the three rescale stages
  typedef struct packed {
    logic mul;
    logic rnd;
    logic shf;
  } rs_en_t;

endpackage

### hdl/qia_regs.sv
module qia_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [qia_pkg::ADDR_W-1:0]     paddr,
  input  logic [qia_pkg::DATA_W-1:0]     pwdata,
  output logic [qia_pkg::DATA_W-1:0]     prdata,
  output logic                           pready,
  output qia_pkg::cfg_t                  cfg_o
);

  qia_pkg::cfg_t    cfg_q, cfg_d;
  qia_pkg::reg_idx_e idx;
  logic             wr;

  assign idx    = qia_pkg::reg_idx_e'(paddr[qia_pkg::ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Decode the write word into the addressed register
  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      case (idx)
        qia_pkg::REG_A_MULT:    cfg_d.a_mult    = pwdata[qia_pkg::MULT_W-1:0];
        qia_pkg::REG_A_SHIFT:   cfg_d.a_shift   = pwdata[qia_pkg::SHIFT_W-1:0];
        qia_pkg::REG_B_MULT:    cfg_d.b_mult    = pwdata[qia_pkg::MULT_W-1:0];
        qia_pkg::REG_B_SHIFT:   cfg_d.b_shift   = pwdata[qia_pkg::SHIFT_W-1:0];
        qia_pkg::REG_OUT_MULT:  cfg_d.out_mult  = pwdata[qia_pkg::MULT_W-1:0];
        qia_pkg::REG_OUT_SHIFT: cfg_d.out_shift = pwdata[qia_pkg::SHIFT_W-1:0];
        qia_pkg::REG_CLAMP_LO:  cfg_d.clamp_lo  = $signed(pwdata[qia_pkg::VAL_W-1:0]);
        qia_pkg::REG_CLAMP_HI:  cfg_d.clamp_hi  = $signed(pwdata[qia_pkg::VAL_W-1:0]);
        default: ;
      endcase
    end
  end

  // Hold the register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.a_mult    <= qia_pkg::MULT_RST;
      cfg_q.a_shift   <= '0;
      cfg_q.b_mult    <= qia_pkg::MULT_RST;
      cfg_q.b_shift   <= '0;
      cfg_q.out_mult  <= qia_pkg::MULT_RST;
      cfg_q.out_shift <= '0;
      cfg_q.clamp_lo  <= qia_pkg::CLAMP_LO_RST;
      cfg_q.clamp_hi  <= qia_pkg::CLAMP_HI_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back, clamp limits sign-extended
  always_comb begin
    case (idx)
      qia_pkg::REG_A_MULT:    prdata = {1'b0, cfg_q.a_mult};
      qia_pkg::REG_A_SHIFT:   prdata = {27'd0, cfg_q.a_shift};
      qia_pkg::REG_B_MULT:    prdata = {1'b0, cfg_q.b_mult};
      qia_pkg::REG_B_SHIFT:   prdata = {27'd0, cfg_q.b_shift};
      qia_pkg::REG_OUT_MULT:  prdata = {1'b0, cfg_q.out_mult};
      qia_pkg::REG_OUT_SHIFT: prdata = {27'd0, cfg_q.out_shift};
      qia_pkg::REG_CLAMP_LO:  prdata = {{16{cfg_q.clamp_lo[15]}}, cfg_q.clamp_lo};
      qia_pkg::REG_CLAMP_HI:  prdata = {{16{cfg_q.clamp_hi[15]}}, cfg_q.clamp_hi};
      default:                prdata = '0;
    endcase
  end

endmodule

### hdl/qia_rescale.sv
// Three-stage rescale: multiply, rounding doubling high part, rounding right shift.
module qia_rescale (
  input  logic                              clk_i,
  input  qia_pkg::rs_en_t                   en_i,
  input  logic signed [qia_pkg::RS_W-1:0]   x_i,
  input  logic [qia_pkg::MULT_W-1:0]        mult_i,
  input  logic [qia_pkg::SHIFT_W-1:0]       shift_i,
  output logic signed [qia_pkg::RS_W-1:0]   y_o
);

  logic signed [qia_pkg::PROD_W-1:0] prod_q, prod_d;
  logic signed [qia_pkg::PROD_W-1:0] biased;
  logic signed [qia_pkg::RS_W-1:0]   hm_q, hm_d;
  logic signed [qia_pkg::RS_W-1:0]   y_q, y_d;
  logic signed [qia_pkg::RS_W-1:0]   quot;
  logic [qia_pkg::RS_W-1:0]          mask;
  logic [qia_pkg::RS_W-1:0]          rem;
  logic [qia_pkg::RS_W-1:0]          thr;
  logic                              inc;

  // Stage 1: full product, multiplier taken as non-negative
  assign prod_d = qia_pkg::PROD_W'(x_i) * qia_pkg::PROD_W'($signed({1'b0, mult_i}));

  // Stage 2: add 2^30 and keep bits 62:31 (rounds to nearest in both signs)
  assign biased = prod_q + qia_pkg::ROUND_BIAS;
  assign hm_d   = biased[qia_pkg::PROD_W-2:qia_pkg::RS_W-1];

  // Stage 3: floor shift, then bump when the dropped part passes the tie point
  always_comb begin
    quot = hm_q >>> shift_i;
    mask = (qia_pkg::RS_W'(1) << shift_i) - qia_pkg::RS_W'(1);
    rem  = hm_q & mask;
    thr  = (mask >> 1) + {{(qia_pkg::RS_W-1){1'b0}}, hm_q[qia_pkg::RS_W-1]};
    inc  = rem > thr;
    y_d  = quot + $signed({{(qia_pkg::RS_W-1){1'b0}}, inc});
  end

  // Advance each stage on its own enable
  always_ff @(posedge clk_i) begin
    if (en_i.mul) begin
      prod_q <= prod_d;
    end
    if (en_i.rnd) begin
      hm_q <= hm_d;
    end
    if (en_i.shf) begin
      y_q <= y_d;
    end
  end

  assign y_o = y_q;

endmodule

### hdl/quantized_int16_add.sv
// Channel   Direction  Handshake                  Words
// input     in         in_valid_i / in_ready_o    a_val_i, b_val_i
// output    out        out_valid_o / out_ready_i  sum_val_o
// config    in         psel, penable, pwrite      paddr, pwdata -> prdata
//
// Each accepted word passes through the eight-stage pipeline (two rescales of three
// stages each, a sum stage and a clamp stage) before result valid rises; one word
// per cycle is sustained while out_ready_i holds high. Each stage loads when it is
// empty or the stage after it loads, so bubbles close up and a stalled output still
// lets the input fill empty stages. Reset clears all stage valid bits and loads the
// register defaults; no clearing pass is needed.
module quantized_int16_add (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [qia_pkg::VAL_W-1:0]    a_val_i,
  input  logic signed [qia_pkg::VAL_W-1:0]    b_val_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [qia_pkg::VAL_W-1:0]    sum_val_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [qia_pkg::ADDR_W-1:0]          paddr,
  input  logic [qia_pkg::DATA_W-1:0]          pwdata,
  output logic [qia_pkg::DATA_W-1:0]          prdata,
  output logic                                pready
);

  qia_pkg::cfg_t                      cfg;
  logic [qia_pkg::NSTG-1:0]           v_q;
  logic [qia_pkg::NSTG-1:0]           en;
  qia_pkg::rs_en_t                    en_op, en_out;
  logic signed [qia_pkg::RS_W-1:0]    a_ext, b_ext;
  logic signed [qia_pkg::RS_W-1:0]    sa, sb, raw;
  logic signed [qia_pkg::RS_W-1:0]    sum_q, sum_d;
  logic signed [qia_pkg::RS_W-1:0]    lo_ext, hi_ext, clip;
  logic signed [qia_pkg::VAL_W-1:0]   out_q, out_d;

  qia_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Stage enables: load when empty or when the next stage loads
  always_comb begin
    en[qia_pkg::NSTG-1] = !v_q[qia_pkg::NSTG-1] || out_ready_i;
    for (int k = qia_pkg::NSTG - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];
  assign en_op      = '{mul: en[0], rnd: en[1], shf: en[2]};
  assign en_out     = '{mul: en[4], rnd: en[5], shf: en[6]};

  // Advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < qia_pkg::NSTG; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Widen operands and apply the fixed pre-scale
  assign a_ext = qia_pkg::RS_W'(a_val_i) <<< qia_pkg::PRE_SHIFT;
  assign b_ext = qia_pkg::RS_W'(b_val_i) <<< qia_pkg::PRE_SHIFT;

  qia_rescale u_rs_a (
    .clk_i   (clk_i),
    .en_i    (en_op),
    .x_i     (a_ext),
    .mult_i  (cfg.a_mult),
    .shift_i (cfg.a_shift),
    .y_o     (sa)
  );

  qia_rescale u_rs_b (
    .clk_i   (clk_i),
    .en_i    (en_op),
    .x_i     (b_ext),
    .mult_i  (cfg.b_mult),
    .shift_i (cfg.b_shift),
    .y_o     (sb)
  );

  // Sum the scaled operands
  assign sum_d = sa + sb;

  qia_rescale u_rs_out (
    .clk_i   (clk_i),
    .en_i    (en_out),
    .x_i     (sum_q),
    .mult_i  (cfg.out_mult),
    .shift_i (cfg.out_shift),
    .y_o     (raw)
  );

  // Clamp: minimum first, maximum last
  always_comb begin
    lo_ext = qia_pkg::RS_W'($signed(cfg.clamp_lo));
    hi_ext = qia_pkg::RS_W'($signed(cfg.clamp_hi));
    clip   = raw;
    if (clip < lo_ext) begin
      clip = lo_ext;
    end
    if (clip > hi_ext) begin
      clip = hi_ext;
    end
    out_d = clip[qia_pkg::VAL_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      sum_q <= sum_d;
    end
    if (en[7]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = v_q[qia_pkg::NSTG-1];
  assign sum_val_o   = out_q;

`include "quantized_int16_add_assert.svh"

  `QIA_ASSERT(a_drain_frees_input, out_ready_i, in_ready_o, "output taken but input stalled")
  `QIA_ASSERT(a_bubble_frees_input, !(&v_q), in_ready_o, "empty stage but input stalled")
  `QIA_ASSERT_NEXT(a_accept_loads, in_valid_i && in_ready_o, v_q[0], "accepted word lost")

endmodule

### bench/quantized_int16_add_tb.sv
module quantized_int16_add_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import qia_pkg::*;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_e;

  // One line of the directed table: a register write or one operand pair
  typedef struct packed {
    row_kind_e               kind;
    reg_idx_e                idx;
    logic [31:0]             data;
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] b;
    logic                    typed;
    logic signed [VAL_W-1:0] sum;
  } dir_row_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] b;
    logic signed [VAL_W-1:0] sum;
  } sum_exp_t;

  localparam int unsigned DIR_ROWS      = 35;
  localparam int unsigned RAND_PHASES   = 8;
  localparam int unsigned WORDS_PER_SET = 192;

  // At reset settings the sum is clamp((a + b) * 1024)
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{ROW_WORD, REG_A_MULT,    32'h0000_0000,  16'sd0,      16'sd0,     1'b1,  16'sd0},
    '{ROW_WORD, REG_A_MULT,    32'h0000_0000,  16'sd1,      16'sd0,     1'b1,  16'sd1024},
    '{ROW_WORD, REG_A_MULT,    32'h0000_0000,  16'sd0,     -16'sd1,     1'b1, -16'sd1024},
    '{ROW_WORD, REG_A_MULT,    32'h0000_0000,  16'sd31,     16'sd0,     1'b1,  16'sd31744},
    '{ROW_WORD, REG_A_MULT,    32'h0000_0000,  16'sd16,     16'sd15,    1'b1,  16'sd31744},
    '{ROW_WORD, REG_A_MULT,    32'h0000_0000,  16'sd32767,  16'sd32767, 1'b1,  16'sd32767},
    '{ROW_WORD, REG_A_MULT,    32'h0000_0000, -16'sd32768, -16'sd32768, 1'b1, -16'sd32768},
    '{ROW_WORD, REG_A_MULT,    32'h0000_0000,  16'sd32767, -16'sd32768, 1'b1, -16'sd1024},
    '{ROW_WORD, REG_A_MULT,    32'h0000_0000, -16'sd32,     16'sd0,     1'b1, -16'sd32768},
    // inverted clamp range, upper data bits set: result is always clamp_high
    '{ROW_CFG,  REG_CLAMP_LO,  32'h1234_0064,  16'sd0,      16'sd0,     1'b0,  16'sd0},
    '{ROW_CFG,  REG_CLAMP_HI,  32'hABCD_FF9C,  16'sd0,      16'sd0,     1'b0,  16'sd0},
    '{ROW_WORD, REG_A_MULT,    32'h0000_0000,  16'sd0,      16'sd0,     1'b1, -16'sd100},
    '{ROW_WORD, REG_A_MULT,    32'h0000_0000,  16'sd32767,  16'sd32767, 1'b1, -16'sd100},
    '{ROW_WORD, REG_A_MULT,    32'h0000_0000, -16'sd32768, -16'sd32768, 1'b1, -16'sd100},
    // full clamp range back, extreme multipliers and shifts
    '{ROW_CFG,  REG_CLAMP_LO,  32'hFFFF_8000,  16'sd0,      16'sd0,     1'b0,  16'sd0},
    '{ROW_CFG,  REG_CLAMP_HI,  32'h0000_7FFF,  16'sd0,      16'sd0,     1'b0,  16'sd0},
    '{ROW_CFG,  REG_A_MULT,    32'hFFFF_FFFF,  16'sd0,      16'sd0,     1'b0,  16'sd0},
    '{ROW_CFG,  REG_A_SHIFT,   32'hFFFF_FFFF,  16'sd0,      16'sd0,     1'b0,  16'sd0},
    '{ROW_CFG,  REG_B_MULT,    32'h8000_0000,  16'sd0,      16'sd0,     1'b0,  16'sd0},
    '{ROW_CFG,  REG_B_SHIFT,   32'hFFFF_FFE0,  16'sd0,      16'sd0,     1'b0,  16'sd0},
    '{ROW_CFG,  REG_OUT_MULT,  32'h7FFF_FFFF,  16'sd0,      16'sd0,     1'b0,  16'sd0},
    '{ROW_CFG,  REG_OUT_SHIFT, 32'h0000_0000,  16'sd0,      16'sd0,     1'b0,  16'sd0},
    '{ROW_WORD, REG_A_MULT,    32'h0000_0000,  16'sd32767,  16'sd32767, 1'b0,  16'sd0},
    '{ROW_WORD, REG_A_MULT,    32'h0000_0000, -16'sd32768, -16'sd32768, 1'b0,  16'sd0},
    '{ROW_WORD, REG_A_MULT,    32'h0000_0000,  16'sd1,     -16'sd1,     1'b0,  16'sd0},
    '{ROW_WORD, REG_A_MULT,    32'h0000_0000, -16'sd12345,  16'sd999,   1'b0,  16'sd0},
    // zero output multiplier forces zero
    '{ROW_CFG,  REG_OUT_MULT,  32'h0000_0000,  16'sd0,      16'sd0,     1'b0,  16'sd0},
    '{ROW_WORD, REG_A_MULT,    32'h0000_0000,  16'sd32767, -16'sd32768, 1'b1,  16'sd0},
    // widest output shift
    '{ROW_CFG,  REG_A_MULT,    32'h4000_0000,  16'sd0,      16'sd0,     1'b0,  16'sd0},
    '{ROW_CFG,  REG_A_SHIFT,   32'h0000_0000,  16'sd0,      16'sd0,     1'b0,  16'sd0},
    '{ROW_CFG,  REG_B_MULT,    32'h4000_0000,  16'sd0,      16'sd0,     1'b0,  16'sd0},
    '{ROW_CFG,  REG_OUT_MULT,  32'h7FFF_FFFF,  16'sd0,      16'sd0,     1'b0,  16'sd0},
    '{ROW_CFG,  REG_OUT_SHIFT, 32'h0000_001F,  16'sd0,      16'sd0,     1'b0,  16'sd0},
    '{ROW_WORD, REG_A_MULT,    32'h0000_0000,  16'sd32767,  16'sd32767, 1'b0,  16'sd0},
    '{ROW_WORD, REG_A_MULT,    32'h0000_0000, -16'sd32768, -16'sd32768, 1'b0,  16'sd0}
  };

  localparam logic signed [VAL_W-1:0] CORNER_VALS [7] = '{
    -16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32766, 16'sd32767
  };

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic signed [VAL_W-1:0] a_val_i;
  logic signed [VAL_W-1:0] b_val_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic signed [VAL_W-1:0] sum_val_o;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [ADDR_W-1:0]       paddr;
  logic [DATA_W-1:0]       pwdata;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;

  cfg_t     add_cfg;
  sum_exp_t pending_sums [$];
  int       error_count;
  int       words_sent;
  int       sums_checked;
  int       clamped_sums;
  int       reg_writes;
  int       send_calm;
  int       recv_calm;

  quantized_int16_add DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .a_val_i     (a_val_i),
    .b_val_i     (b_val_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sum_val_o   (sum_val_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Q31 doubling high multiply, then rounding right shift, ties away from zero
  function automatic longint q31_rescale(longint x, logic [MULT_W-1:0] m,
                                         logic [SHIFT_W-1:0] s);
    longint prod;
    longint nudge;
    longint hm;
    longint mask;
    longint thr;
    prod  = x * longint'(m);
    nudge = (prod >= 0) ? (longint'(1) <<< 30) : (longint'(1) - (longint'(1) <<< 30));
    hm    = (prod + nudge) / (longint'(1) <<< 31);
    mask  = (longint'(1) <<< s) - 1;
    thr   = (mask >>> 1) + ((hm < 0) ? 1 : 0);
    return (hm >>> s) + (((hm & mask) > thr) ? 1 : 0);
  endfunction

  // Rescale both operands, add, rescale the sum, clamp (min first, then max)
  function automatic logic signed [VAL_W-1:0] predict_sum(logic signed [VAL_W-1:0] a,
                                                          logic signed [VAL_W-1:0] b);
    longint sa;
    longint sb;
    longint raw;
    sa  = q31_rescale(longint'(a) <<< PRE_SHIFT, add_cfg.a_mult, add_cfg.a_shift);
    sb  = q31_rescale(longint'(b) <<< PRE_SHIFT, add_cfg.b_mult, add_cfg.b_shift);
    raw = q31_rescale(sa + sb, add_cfg.out_mult, add_cfg.out_shift);
    if (raw < longint'($signed(add_cfg.clamp_lo))) begin
      raw = longint'($signed(add_cfg.clamp_lo));
    end
    if (raw > longint'($signed(add_cfg.clamp_hi))) begin
      raw = longint'($signed(add_cfg.clamp_hi));
    end
    return raw[VAL_W-1:0];
  endfunction

  // Idle cycles before the next word; now and then a calm stretch with none
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  function automatic logic [MULT_W-1:0] pick_mult();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return MULT_RST;
      default: return {1'b1, 30'($urandom)};
    endcase
  endfunction

  function automatic logic [SHIFT_W-1:0] pick_shift(int unsigned top);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return SHIFT_W'($urandom_range(0, top));
    endcase
  endfunction

  // Register write: setup phase, access phase held until pready, then idle
  task automatic reg_write(reg_idx_e idx, logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    reg_writes++;
    case (idx)
      REG_A_MULT:    add_cfg.a_mult    = data[MULT_W-1:0];
      REG_A_SHIFT:   add_cfg.a_shift   = data[SHIFT_W-1:0];
      REG_B_MULT:    add_cfg.b_mult    = data[MULT_W-1:0];
      REG_B_SHIFT:   add_cfg.b_shift   = data[SHIFT_W-1:0];
      REG_OUT_MULT:  add_cfg.out_mult  = data[MULT_W-1:0];
      REG_OUT_SHIFT: add_cfg.out_shift = data[SHIFT_W-1:0];
      REG_CLAMP_LO:  add_cfg.clamp_lo  = data[VAL_W-1:0];
      REG_CLAMP_HI:  add_cfg.clamp_hi  = data[VAL_W-1:0];
      default: ;
    endcase
  endtask

  // Drop valid and hold until every pending sum has come back
  task automatic drain_sums();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_sums.size() != 0);
  endtask

  // Offer one operand pair; record its expected sum once accepted
  task automatic send_word(logic signed [VAL_W-1:0] a, logic signed [VAL_W-1:0] b,
                           logic typed, logic signed [VAL_W-1:0] typed_sum);
    int       gap;
    sum_exp_t exp_sum;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    a_val_i    <= a;
    b_val_i    <= b;
    do @(posedge clk_i); while (!in_ready_o);
    exp_sum.a   = a;
    exp_sum.b   = b;
    exp_sum.sum = typed ? typed_sum : predict_sum(a, b);
    if (exp_sum.sum == add_cfg.clamp_lo || exp_sum.sum == add_cfg.clamp_hi) begin
      clamped_sums++;
    end
    pending_sums.push_back(exp_sum);
    words_sent++;
  endtask

  // Write every register with a fresh random setting, junk in unused bits
  task automatic random_setting();
    logic signed [VAL_W-1:0] t1;
    logic signed [VAL_W-1:0] t2;
    logic signed [VAL_W-1:0] lo;
    logic signed [VAL_W-1:0] hi;
    t1 = VAL_W'($urandom);
    t2 = VAL_W'($urandom);
    case ($urandom_range(0, 5))
      0: begin
        lo = CLAMP_LO_RST;
        hi = CLAMP_HI_RST;
      end
      1: begin
        lo = (t1 > t2) ? t1 : t2;
        hi = (t1 > t2) ? t2 : t1;
      end
      default: begin
        lo = (t1 > t2) ? t2 : t1;
        hi = (t1 > t2) ? t1 : t2;
      end
    endcase
    reg_write(REG_A_MULT,    {1'($urandom), pick_mult()});
    reg_write(REG_A_SHIFT,   {27'($urandom), pick_shift(6)});
    reg_write(REG_B_MULT,    {1'($urandom), pick_mult()});
    reg_write(REG_B_SHIFT,   {27'($urandom), pick_shift(6)});
    reg_write(REG_OUT_MULT,  {1'($urandom), pick_mult()});
    reg_write(REG_OUT_SHIFT, {27'($urandom), pick_shift(14)});
    reg_write(REG_CLAMP_LO,  {16'($urandom), lo});
    reg_write(REG_CLAMP_HI,  {16'($urandom), hi});
  endtask

  task automatic random_word();
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] b;
    int                      tmp;
    a = VAL_W'($urandom);
    b = VAL_W'($urandom);
    case ($urandom_range(0, 9))
      0, 1: begin
        tmp = $urandom_range(0, 127);
        a   = VAL_W'(tmp - 64);
        tmp = $urandom_range(0, 127);
        b   = VAL_W'(tmp - 64);
      end
      2: begin
        a = CORNER_VALS[$urandom_range(0, 6)];
        b = CORNER_VALS[$urandom_range(0, 6)];
      end
      3: b = -a;
      default: ;
    endcase
    send_word(a, b, 1'b0, '0);
  endtask

  // Output side: stall a random number of cycles, then take one word
  initial begin
    int stall;
    out_ready_i = 1'b0;
    recv_calm   = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = draw_wait(recv_calm);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Compare each accepted sum with the oldest expectation
  always @(posedge clk_i) begin
    sum_exp_t exp_sum;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_sums.size() == 0) begin
        $display("%0t: unexpected sum_val_o %0d, no sum pending", $time, sum_val_o);
        error_count++;
      end else begin
        exp_sum = pending_sums.pop_front();
        sums_checked++;
        if (sum_val_o !== exp_sum.sum) begin
          $display("%0t: sum_val_o mismatch for a=%0d b=%0d: expected %0d, actual %0d",
                   $time, exp_sum.a, exp_sum.b, exp_sum.sum, sum_val_o);
          error_count++;
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("%0t: timeout, %0d sums still pending", $time, pending_sums.size());
    $display("FAIL");
    $finish;
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    a_val_i      = '0;
    b_val_i      = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    error_count  = 0;
    words_sent   = 0;
    sums_checked = 0;
    clamped_sums = 0;
    reg_writes   = 0;
    send_calm    = 0;
    add_cfg      = '{a_mult: MULT_RST, a_shift: '0, b_mult: MULT_RST, b_shift: '0,
                     out_mult: MULT_RST, out_shift: '0,
                     clamp_lo: CLAMP_LO_RST, clamp_hi: CLAMP_HI_RST};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: register writes only once the pipeline is empty
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIR_TABLE[i].kind == ROW_CFG) begin
        drain_sums();
        reg_write(DIR_TABLE[i].idx, DIR_TABLE[i].data);
      end else begin
        send_word(DIR_TABLE[i].a, DIR_TABLE[i].b, DIR_TABLE[i].typed, DIR_TABLE[i].sum);
      end
    end

    // Random settings, each followed by a stream of random pairs
    for (int p = 0; p < RAND_PHASES; p++) begin
      drain_sums();
      random_setting();
      repeat (WORDS_PER_SET) random_word();
    end

    drain_sums();
    repeat (2 * NSTG + 4) @(posedge clk_i);
    $display("Sent %0d operand pairs over %0d register writes (%0d random settings).",
             words_sent, reg_writes, RAND_PHASES);
    $display("Checked %0d sums, %0d of them at a clamp bound, %0d errors.",
             sums_checked, clamped_sums, error_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/qia_pkg.sv
hdl/qia_regs.sv
hdl/qia_rescale.sv
hdl/quantized_int16_add.sv
bench/quantized_int16_add_tb.sv
